FILE: rtl/core/matrix_multiply_top_assert.svh
// Assertion macros for the matrix multiply block and its checker.
// Both macros expect signals named i_clk and i_rst_n in the calling scope.
`ifndef MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define MATRIX_MULTIPLY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("matrix_multiply_top: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("matrix_multiply_top: next-cycle check failed");

`endif

FILE: rtl/core/mm_pkg.sv
// Shared constants, codes and types of the matrix multiply block.
// No dependencies; imported by every module of the block except the RAM.
`timescale 1ns / 1ps

package mm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int RAM_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);
    localparam int FIELD_IDX_W = 3;
    localparam int VAL_W       = 16;
    localparam int MUL_W       = 2 * VAL_W;
    localparam int PROD_W      = 35;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET_DIM = 4'd8;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_START   = 2'd2
    } t_opcode;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_el;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_mac_ctrl;

endpackage

FILE: rtl/core/mm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mm_mac.sv
// Multiply-accumulate datapath with the result output register.
// Depends on mm_pkg; fed by the element RAM read ports of the top level.
`timescale 1ns / 1ps

module mm_mac
    import mm_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctrl                     i_ctrl,
    input  logic signed [VAL_W-1:0]       i_a,
    input  logic signed [VAL_W-1:0]       i_b,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [PROD_W-1:0]      o_prod_value,
    output logic [FIELD_IDX_W-1:0]        o_out_row,
    output logic [FIELD_IDX_W-1:0]        o_out_col,
    output logic                          o_last
);

    t_mac_ctrl                   r_c1;
    t_mac_ctrl                   r_c2;
    logic signed [MUL_W-1:0]     r_prod;
    logic signed [PROD_W-1:0]    r_acc;
    logic signed [PROD_W-1:0]    n_acc;
    logic signed [PROD_W-1:0]    prod_ext;
    logic                        r_out_valid;
    logic signed [PROD_W-1:0]    r_out_value;
    logic [IDX_W-1:0]            r_out_row;
    logic [IDX_W-1:0]            r_out_col;
    logic                        r_out_last;

    assign prod_ext = PROD_W'(r_prod);
    assign n_acc    = r_c2.first ? prod_ext : r_acc + prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid  <= 1'b0;
            r_c2.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_c1 <= i_ctrl;
            r_c2 <= r_c1;
            if (r_c2.valid && r_c2.last_k) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_W'(i_a) * MUL_W'(i_b);
        if (r_c2.valid) begin
            r_acc <= n_acc;
        end
        if (r_c2.valid && r_c2.last_k) begin
            r_out_value <= n_acc;
            r_out_row   <= r_c2.row;
            r_out_col   <= r_c2.col;
            r_out_last  <= r_c2.last_el;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_prod_value = r_out_value;
    assign o_out_row    = FIELD_IDX_W'(r_out_row);
    assign o_out_col    = FIELD_IDX_W'(r_out_col);
    assign o_last       = r_out_last;

endmodule

FILE: rtl/core/matrix_multiply_top.sv
// Matrix multiply top: element writes give no result. The inner-product loop of
// a start runs on one multiplier fed by the two RAM read ports, with one result
// element in flight; each element waits until the previous result is taken.
// Reset is synchronous, active low; it sets the dimensions to 8 and leaves the
// element RAMs unwritten.
`timescale 1ns / 1ps

module matrix_multiply_top
    import mm_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [FIELD_IDX_W-1:0]        i_row_index,
    input  logic [FIELD_IDX_W-1:0]        i_col_index,
    input  logic signed [VAL_W-1:0]       i_elem_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [PROD_W-1:0]      o_prod_value,
    output logic [FIELD_IDX_W-1:0]        o_out_row,
    output logic [FIELD_IDX_W-1:0]        o_out_col,
    output logic                          o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_RUN
    } t_state;

    t_state            r_state;
    logic [CFG_W-1:0]  r_cfg_rows;
    logic [CFG_W-1:0]  r_cfg_inner;
    logic [CFG_W-1:0]  r_cfg_cols;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic [IDX_W-1:0]  r_k;
    logic              r_inflight;

    logic [CFG_W-1:0]  dim_m;
    logic [CFG_W-1:0]  dim_n;
    logic [CFG_W-1:0]  dim_p;
    logic              in_accept;
    logic              out_accept;
    logic              wr_in_range;
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [VAL_W-1:0]  rdata_a;
    logic [VAL_W-1:0]  rdata_b;
    logic              i_last;
    logic              j_last;
    logic              k_last;
    t_mac_ctrl         issue_ctrl;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] res;
        res = d;
        if (d == '0) begin
            res = CFG_W'(1);
        end else if (d > MAX_DIM) begin
            res = CFG_W'(MAX_DIM);
        end
        return res;
    endfunction

    assign dim_m = clamp_dim(r_cfg_rows);
    assign dim_n = clamp_dim(r_cfg_inner);
    assign dim_p = clamp_dim(r_cfg_cols);

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_accept = o_out_valid && i_out_ready;

    assign wr_in_range = (i_row_index < MAX_DIM) && (i_col_index < MAX_DIM);
    assign we_a  = in_accept && wr_in_range && (i_opcode == OP_WRITE_A);
    assign we_b  = in_accept && wr_in_range && (i_opcode == OP_WRITE_B);
    assign waddr = ADDR_W'(i_row_index * MAX_DIM + i_col_index);

    assign raddr_a = ADDR_W'(r_i * MAX_DIM + r_k);
    assign raddr_b = ADDR_W'(r_k * MAX_DIM + r_j);

    assign i_last = (r_i == IDX_W'(dim_m - CFG_W'(1)));
    assign j_last = (r_j == IDX_W'(dim_p - CFG_W'(1)));
    assign k_last = (r_k == IDX_W'(dim_n - CFG_W'(1)));

    assign issue_ctrl.valid   = (r_state == S_RUN);
    assign issue_ctrl.first   = (r_k == '0);
    assign issue_ctrl.last_k  = k_last;
    assign issue_ctrl.last_el = i_last && j_last;
    assign issue_ctrl.row     = r_i;
    assign issue_ctrl.col     = r_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_rows  <= CFG_RESET_DIM;
            r_cfg_inner <= CFG_RESET_DIM;
            r_cfg_cols  <= CFG_RESET_DIM;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_inflight  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROWS_A:    r_cfg_rows  <= i_cfg_data;
                    CFG_INNER_DIM: r_cfg_inner <= i_cfg_data;
                    CFG_COLS_B:    r_cfg_cols  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_accept) begin
                r_inflight <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && (i_opcode == OP_START)) begin
                        r_state <= S_WAIT;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                    end
                end
                S_WAIT: begin
                    if (!r_inflight) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (k_last) begin
                        r_k        <= '0;
                        r_inflight <= 1'b1;
                        if (j_last) begin
                            r_j <= '0;
                            if (i_last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_i     <= r_i + IDX_W'(1);
                                r_state <= S_WAIT;
                            end
                        end else begin
                            r_j     <= r_j + IDX_W'(1);
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    mm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_elem_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_elem_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    mm_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (issue_ctrl),
        .i_a          (rdata_a),
        .i_b          (rdata_b),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_prod_value (o_prod_value),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_last       (o_last)
    );

endmodule

FILE: rtl/core/mm_checker.sv
// Port-level checker for the matrix multiply top, bound to it below.
// Depends on mm_pkg and the assertion macros in matrix_multiply_top_assert.svh.
`timescale 1ns / 1ps
`include "matrix_multiply_top_assert.svh"

module mm_checker
    import mm_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [1:0]                    i_opcode,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [PROD_W-1:0]      o_prod_value,
    input logic [FIELD_IDX_W-1:0]        o_out_row,
    input logic [FIELD_IDX_W-1:0]        o_out_col,
    input logic                          o_last
);

    logic [PROD_W+2*FIELD_IDX_W:0] out_fields;

    assign out_fields = {o_prod_value, o_out_row, o_out_col, o_last};

    // A stalled result must hold until it is taken.
    `MM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_fields))

    // An accepted start blocks further requests while the product runs.
    `MM_ASSERT_NEXT(a_start_blocks, i_in_valid && o_in_ready && (i_opcode == OP_START), !o_in_ready)

    // While a result other than the final one waits, the product is still running.
    `MM_ASSERT_SAME(a_busy_mid_product, o_out_valid && !o_last, !o_in_ready)

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (.*);
